// ----- rtl/fircb_pkg.sv -----
// ----------------------------------------------------------------------------
// fircb_pkg
// shared constants and types for the circular-buffer fir filter
// ----------------------------------------------------------------------------
package fircb_pkg;

  // number of filter taps (delay line and coefficient store depth)
  localparam int TAPS = 32;

  // index width into the tap memories
  localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  // field widths of the stream items
  localparam int TAP_FIELD_W = 5;
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int OUT_W       = 37;

  // packed bus widths, padded to whole bytes
  localparam int IN_DATA_W  = ((TAP_FIELD_W + SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  // request kinds carried on tuser
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_COEF   = 1'b1
  } kind_t;

endpackage

// ----- rtl/fircb_ram.sv -----
// ----------------------------------------------------------------------------
// fircb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fircb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fir_filter_circular_buffer.sv -----
// ----------------------------------------------------------------------------
// fir_filter_circular_buffer
// direct-form fir filter with a circular delay line and one shared mac
// ----------------------------------------------------------------------------
// usage:
//   requests enter on the in_ stream. tuser carries the kind: a sample
//   request writes the newest sample over the oldest delay line slot and
//   produces one filtered result; a coefficient request writes one tap
//   (tap_index beyond the tap count is dropped) and produces no result.
//   results leave on the out_ stream as a 37-bit signed sum in q.30 scale.
// timing:
//   a sample request runs TAPS reads of both tap memories through one
//   multiplier and one accumulator, one tap per cycle; the reads, the
//   product and the accumulator are registered in turn, and the finished
//   sum is then loaded into the output register. in_tready stays low while
//   a sample is in flight, so the next request is taken only after its
//   result is loaded into the output register.
// stall:
//   the output register parts the two sides; the next request is taken
//   while a result still waits. a finished sum waits in the accumulator
//   until the output register is free, with in_tready low.
// reset:
//   rst_n is synchronous, active low. the write pointer is reset to zero,
//   and the delay line and the coefficients read as zero afterwards through
//   per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module fir_filter_circular_buffer (
  input  logic                             clk,
  input  logic                             rst_n,
  // request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [4:0] tap_index, [20:5] value, [23:21] zero
  input  logic [fircb_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                             in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [36:0] filtered, [39:37] zero
  output logic [fircb_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W = fircb_pkg::IDX_W;
  localparam int SW    = fircb_pkg::SAMPLE_W;
  localparam int PW    = fircb_pkg::PROD_W;
  localparam int OW    = fircb_pkg::OUT_W;
  localparam int TFW   = fircb_pkg::TAP_FIELD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  // control state
  state_t                   state_r;
  logic [IDX_W-1:0]         wp_r;       // slot of the oldest sample
  logic [IDX_W-1:0]         k_r;        // tap being read
  logic [IDX_W-1:0]         slot_r;     // delay line slot for tap k
  logic [fircb_pkg::TAPS-1:0] dl_vld_r;
  logic [fircb_pkg::TAPS-1:0] cf_vld_r;
  logic                     rd_v_r;
  logic                     rd_last_r;
  logic                     mul_v_r;
  logic                     mul_last_r;
  logic                     done_r;
  logic                     out_tvalid_r;

  // datapath
  logic                     dvld_r;
  logic                     cvld_r;
  logic signed [PW-1:0]     prod_r;
  logic [OW-1:0]            acc_r;
  logic [OW-1:0]            out_data_r;

  // request decode
  logic                     in_fire;
  logic                     is_samp;
  logic                     is_coef;
  logic                     tap_ok;
  logic [31:0]              tap_wide;
  logic [IDX_W-1:0]         coef_waddr;
  logic signed [SW-1:0]     in_value;
  logic                     issue;
  logic                     issue_last;
  logic                     out_load;

  // memory read data
  logic [SW-1:0]            dl_rdata;
  logic [SW-1:0]            cf_rdata;
  logic signed [SW-1:0]     samp_s;
  logic signed [SW-1:0]     coef_s;

  always_comb begin
    in_tready  = (state_r == S_IDLE);
    in_fire    = in_tvalid & in_tready;
    in_value   = in_tdata[TFW +: SW];
    tap_wide   = 32'(in_tdata[TFW-1:0]);
    tap_ok     = (tap_wide < 32'(fircb_pkg::TAPS));
    coef_waddr = tap_wide[IDX_W-1:0];
    is_samp    = in_fire & (in_tuser == fircb_pkg::KIND_SAMPLE);
    is_coef    = in_fire & (in_tuser == fircb_pkg::KIND_COEF) & tap_ok;
    issue      = (state_r == S_RUN);
    issue_last = issue & (k_r == IDX_W'(fircb_pkg::TAPS - 1));
    out_load   = (state_r == S_FLUSH) & done_r & (~out_tvalid_r | out_tready);
    // entries never written read as zero
    samp_s     = dvld_r ? dl_rdata : '0;
    coef_s     = cvld_r ? cf_rdata : '0;
  end

  fircb_ram #(
    .WIDTH (SW),
    .DEPTH (fircb_pkg::TAPS),
    .AW    (IDX_W)
  ) u_delay_ram (
    .clk   (clk),
    .we    (is_samp),
    .waddr (wp_r),
    .wdata (in_value),
    .raddr (slot_r),
    .rdata (dl_rdata)
  );

  fircb_ram #(
    .WIDTH (SW),
    .DEPTH (fircb_pkg::TAPS),
    .AW    (IDX_W)
  ) u_coef_ram (
    .clk   (clk),
    .we    (is_coef),
    .waddr (coef_waddr),
    .wdata (in_value),
    .raddr (k_r),
    .rdata (cf_rdata)
  );

  // control: state, pointers, valid bits, pipeline flags, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wp_r         <= '0;
      k_r          <= '0;
      slot_r       <= '0;
      dl_vld_r     <= '0;
      cf_vld_r     <= '0;
      rd_v_r       <= 1'b0;
      rd_last_r    <= 1'b0;
      mul_v_r      <= 1'b0;
      mul_last_r   <= 1'b0;
      done_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (is_samp) begin
            state_r        <= S_RUN;
            k_r            <= '0;
            slot_r         <= wp_r;
            dl_vld_r[wp_r] <= 1'b1;
            wp_r <= (wp_r == IDX_W'(fircb_pkg::TAPS - 1)) ? '0 : wp_r + 1'b1;
          end
          if (is_coef) begin
            cf_vld_r[coef_waddr] <= 1'b1;
          end
        end
        S_RUN: begin
          k_r    <= k_r + 1'b1;
          // walk back from the newest sample
          slot_r <= (slot_r == '0) ? IDX_W'(fircb_pkg::TAPS - 1) : slot_r - 1'b1;
          if (issue_last) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      rd_v_r     <= issue;
      rd_last_r  <= issue_last;
      mul_v_r    <= rd_v_r;
      mul_last_r <= rd_last_r;

      if (out_load) begin
        done_r <= 1'b0;
      end else if (mul_v_r & mul_last_r) begin
        done_r <= 1'b1;
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath: read masks, product, accumulator, output data
  always_ff @(posedge clk) begin
    dvld_r <= dl_vld_r[slot_r];
    cvld_r <= cf_vld_r[k_r];
    prod_r <= samp_s * coef_s;
    if (is_samp) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      // sum wraps to the output width
      acc_r <= acc_r + {{(OW - PW){prod_r[PW-1]}}, prod_r};
    end
    if (out_load) begin
      out_data_r <= acc_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(fircb_pkg::OUT_DATA_W - OW){1'b0}}, out_data_r};

  // a coefficient write never produces a result
  a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == fircb_pkg::KIND_COEF) |=> !out_load)
    else $error("coefficient write produced a result");

  // a sample starts the tap walk on the next cycle at tap zero
  a_samp_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    is_samp |=> (state_r == S_RUN && k_r == '0))
    else $error("sample did not start tap walk");

  // nothing is in flight while requests are taken
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!rd_v_r && !mul_v_r && !done_r))
    else $error("request taken with mac in flight");

  // the last product is flagged only with a valid product
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mul_last_r |-> mul_v_r)
    else $error("last flag without valid product");

  // the result register is loaded only once the sum is complete
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (done_r && !mul_v_r))
    else $error("result loaded before sum complete");

endmodule

// ----- dv/tb_fir_filter_circular_buffer.sv -----
// ----------------------------------------------------------------------------
// tb_fir_filter_circular_buffer
// self-checking bench for the circular-buffer fir filter
// ----------------------------------------------------------------------------
// a bit-true predictor runs next to the dut: every accepted sample request
// updates its own delay line and produces the expected q.30 sum, which waits
// in a queue until the dut presents a result. coefficient requests only
// update the predicted coefficient store. directed requests cover start-up
// with a partly filled delay line, tap and value extremes and the
// no-result coefficient path, and a long output stall with a full drain
// pause; the random part reprograms whole coefficient sets and streams
// sample bursts, under random idling on both sides, with drain pauses.
// ----------------------------------------------------------------------------
module tb_fir_filter_circular_buffer;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  // request side, known from time zero
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [fircb_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic                             in_tuser  = fircb_pkg::KIND_SAMPLE;

  // result side
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [fircb_pkg::OUT_DATA_W-1:0] out_tdata;

  fir_filter_circular_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // predicted filter state
  logic signed [fircb_pkg::SAMPLE_W-1:0] history   [fircb_pkg::TAPS];
  logic signed [fircb_pkg::SAMPLE_W-1:0] tap_coefs [fircb_pkg::TAPS];
  int unsigned                           oldest_slot;

  // sums still owed by the dut, oldest first
  logic signed [fircb_pkg::OUT_W-1:0] expected_sums [$];

  int mismatch_count = 0;
  int requests_sent  = 0;

  // idling control shared by both sides
  bit no_idle = 1'b0;
  // long receiver stall: loaded by a test, counted down by the receiver
  int stall_request = 0;
  int stall_left    = 0;

  // --------------------------------------------------------------------------
  // predictor: one accepted request in, zero or one expected sum out
  // --------------------------------------------------------------------------
  task automatic predict_filter(input fircb_pkg::kind_t kind,
                                input logic [fircb_pkg::TAP_FIELD_W-1:0] tap,
                                input logic signed [fircb_pkg::SAMPLE_W-1:0] value);
    int unsigned newest;
    int unsigned slot;
    longint      acc;
    if (kind == fircb_pkg::KIND_COEF) begin
      // tap index past the tap count is dropped, no result either way
      if (tap < fircb_pkg::TAPS) tap_coefs[tap] = value;
    end else begin
      newest = oldest_slot;
      history[newest] = value;
      oldest_slot = (newest + 1) % fircb_pkg::TAPS;
      acc = 0;
      // k = 0 pairs with the newest sample
      for (int k = 0; k < fircb_pkg::TAPS; k++) begin
        slot = (newest + fircb_pkg::TAPS - k) % fircb_pkg::TAPS;
        acc += longint'(tap_coefs[k]) * longint'(history[slot]);
      end
      expected_sums.push_back(acc[fircb_pkg::OUT_W-1:0]);
    end
  endtask

  // --------------------------------------------------------------------------
  // sender: random gaps, then hold the request until it is taken
  // --------------------------------------------------------------------------
  task automatic send_request(input fircb_pkg::kind_t kind,
                              input logic [fircb_pkg::TAP_FIELD_W-1:0] tap,
                              input logic signed [fircb_pkg::SAMPLE_W-1:0] value);
    while (!no_idle && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    // [4:0] tap_index, [20:5] value, [23:21] zero
    in_tdata  <= {3'b000, value, tap};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // taken at this edge
    predict_filter(kind, tap, value);
    requests_sent++;
  endtask

  task automatic send_sample(input logic signed [fircb_pkg::SAMPLE_W-1:0] value);
    // tap field is don't-care for samples, so keep it moving
    send_request(fircb_pkg::KIND_SAMPLE, fircb_pkg::TAP_FIELD_W'($urandom), value);
  endtask

  // sender pause until every owed sum has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random back-pressure plus the long stall on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 25);
    end
  end

  // --------------------------------------------------------------------------
  // result checker: each accepted result against the oldest expected sum
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic signed [fircb_pkg::OUT_W-1:0] got;
    logic signed [fircb_pkg::OUT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      got = $signed(out_tdata[fircb_pkg::OUT_W-1:0]);
      if (expected_sums.size() == 0) begin
        mismatch_count++;
        $display("%0t: filtered result with none expected, expected none, actual %0d",
                 $time, got);
      end else begin
        want = expected_sums.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: filtered mismatch, expected %0d, actual %0d", $time, want, got);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // sample styles: full random, rail to rail, negative rail, small, positive rail
  function automatic logic signed [fircb_pkg::SAMPLE_W-1:0] pick_sample(input int style);
    case (style)
      1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2:       return 16'sh8000;
      3:       return 16'($urandom_range(255)) - 16'd128;
      4:       return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // coefficient set styles: random, negative rail, positive rail, one spike,
  // small taps, alternating rails
  function automatic logic signed [fircb_pkg::SAMPLE_W-1:0] pick_coef(input int style,
                                                                      input int tap,
                                                                      input int spike_tap);
    case (style)
      1:       return 16'sh8000;
      2:       return 16'sh7fff;
      3:       return (tap == spike_tap) ? 16'($urandom) : 16'sh0000;
      4:       return 16'($urandom_range(127)) - 16'd64;
      5:       return tap[0] ? 16'sh8000 : 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // zero coefficients give zero sums, then a few taps over a partly filled line
  task automatic test_startup();
    send_sample(16'sd5);
    send_sample(-16'sd7);
    send_sample(16'sh7fff);
    send_request(fircb_pkg::KIND_COEF, 5'd0, 16'sd16384);
    send_request(fircb_pkg::KIND_COEF, 5'd1, 16'sh8000);
    send_request(fircb_pkg::KIND_COEF, 5'd3, 16'sh7fff);
    send_sample(16'sd100);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
  endtask

  // first and last tap at the rails, sample and tap field extremes
  task automatic test_tap_extremes();
    send_request(fircb_pkg::KIND_COEF, 5'd31, 16'sh8000);
    send_request(fircb_pkg::KIND_COEF, 5'd0, 16'sh7fff);
    send_request(fircb_pkg::KIND_SAMPLE, 5'd31, 16'sh8000);
    send_request(fircb_pkg::KIND_SAMPLE, 5'd0, 16'sh7fff);
    send_request(fircb_pkg::KIND_COEF, 5'd31, 16'sh7fff);
    send_request(fircb_pkg::KIND_SAMPLE, 5'd21, 16'sh5555);
    send_request(fircb_pkg::KIND_SAMPLE, 5'd10, 16'shaaaa);
    send_request(fircb_pkg::KIND_COEF, 5'd1, 16'sh0000);
    send_sample(16'sh0000);
    send_sample(16'sd1);
  endtask

  // receiver holds off long enough that the dut fills and blocks requests,
  // then the sender waits for a full drain
  task automatic test_output_stall();
    stall_request = 400;
    for (int i = 0; i < 12; i++) send_sample(pick_sample(0));
    wait_for_results();
    for (int i = 0; i < 4; i++) send_sample(pick_sample(1));
  endtask

  // whole coefficient sets and sample bursts, with coefficient noise and drain pauses mixed in
  task automatic test_random(input int target);
    int pick;
    int style;
    int spike_tap;
    int burst_len;
    while (requests_sent < target) begin
      // one long stretch with no idling on either side
      no_idle = (requests_sent >= 700) && (requests_sent < 1000);
      pick = $urandom_range(99);
      if (pick < 8) begin
        style     = $urandom_range(5);
        spike_tap = $urandom_range(fircb_pkg::TAPS - 1);
        if ($urandom_range(1)) begin
          for (int t = 0; t < fircb_pkg::TAPS; t++)
            send_request(fircb_pkg::KIND_COEF, fircb_pkg::TAP_FIELD_W'(t),
                         pick_coef(style, t, spike_tap));
        end else begin
          for (int t = fircb_pkg::TAPS - 1; t >= 0; t--)
            send_request(fircb_pkg::KIND_COEF, fircb_pkg::TAP_FIELD_W'(t),
                         pick_coef(style, t, spike_tap));
        end
      end else if (pick < 16) begin
        // stray single-tap rewrites
        repeat ($urandom_range(1, 3))
          send_request(fircb_pkg::KIND_COEF, fircb_pkg::TAP_FIELD_W'($urandom),
                       16'($urandom));
      end else if (pick < 18) begin
        wait_for_results();
      end else begin
        style     = $urandom_range(4);
        burst_len = $urandom_range(8, 48);
        repeat (burst_len) send_sample(pick_sample(style));
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < fircb_pkg::TAPS; i++) begin
      history[i]   = '0;
      tap_coefs[i] = '0;
    end
    oldest_slot = 0;

    apply_reset();
    test_startup();
    test_tap_extremes();
    test_output_stall();
    test_random(1800);

    // let every owed sum come back, then a little past the mac latency
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (fircb_pkg::TAPS + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
